FILE: src/wtws_pkg.sv
`timescale 1ns / 1ps

package wtws_pkg;

  // Number of schedule slots that the search covers (1 to 8).
  localparam int unsigned SLOTS = 7;

  // Day code of a slot that matches on every weekday.
  localparam logic [3:0] DAY_ANY = 4'd8;

  // Days in a year for the expiry wrap, and the repeat period while the card is absent.
  localparam logic [11:0] YEAR_DAYS = 12'd365;
  localparam logic [3:0] REPEAT_RELOAD = 4'd9;
  localparam logic [6:0] MIN_PER_HOUR = 7'd60;

  // Message kinds.
  localparam logic MSG_START = 1'b0;
  localparam logic MSG_END = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SLOTS_01 = 3'd0;
  localparam logic [2:0] REG_SLOTS_23 = 3'd1;
  localparam logic [2:0] REG_SLOTS_45 = 3'd2;
  localparam logic [2:0] REG_SLOTS_67 = 3'd3;
  localparam logic [2:0] REG_START_DAY = 3'd4;
  localparam logic [2:0] REG_START_YEAR = 3'd5;
  localparam logic [2:0] REG_RUN_WEEKS = 3'd6;
  localparam logic [2:0] REG_NEVER_EXPIRE = 3'd7;

  // One 32-bit slot descriptor.
  typedef struct packed {
    logic [4:0] rsvd;
    logic [5:0] dur_min;
    logic [4:0] dur_hour;
    logic [5:0] start_min;
    logic [4:0] start_hour;
    logic [3:0] day;
    logic       enable;
  } slot_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [3:0][63:0] slots;
    logic [8:0]       start_day;
    logic [7:0]       start_year;
    logic [7:0]       run_weeks;
    logic             never_expire;
  } cfg_t;

  // One tick, as packed on the input stream.
  typedef struct packed {
    logic [4:0] pad;
    logic       card_absent;
    logic [1:0] rec_dest;
    logic       paused;
    logic [7:0] now_year;
    logic [8:0] now_yday;
    logic [5:0] now_min;
    logic [4:0] now_hour;
    logic [2:0] now_wday;
  } tick_t;

endpackage

FILE: src/wtws_cfg_regs.sv
`timescale 1ns / 1ps

module wtws_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output wtws_pkg::cfg_t   cfg_o
);

  wtws_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[5:3];

  // Register writes in the access phase.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        wtws_pkg::REG_SLOTS_01:     cfg_d.slots[0] = pwdata;
        wtws_pkg::REG_SLOTS_23:     cfg_d.slots[1] = pwdata;
        wtws_pkg::REG_SLOTS_45:     cfg_d.slots[2] = pwdata;
        wtws_pkg::REG_SLOTS_67:     cfg_d.slots[3] = pwdata;
        wtws_pkg::REG_START_DAY:    cfg_d.start_day = pwdata[8:0];
        wtws_pkg::REG_START_YEAR:   cfg_d.start_year = pwdata[7:0];
        wtws_pkg::REG_RUN_WEEKS:    cfg_d.run_weeks = pwdata[7:0];
        wtws_pkg::REG_NEVER_EXPIRE: cfg_d.never_expire = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Everything resets to zero except the expiry disable, which resets to one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{slots: '0, start_day: '0, start_year: '0, run_weeks: '0,
                 never_expire: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (reg_idx)
      wtws_pkg::REG_SLOTS_01:     prdata = cfg_q.slots[0];
      wtws_pkg::REG_SLOTS_23:     prdata = cfg_q.slots[1];
      wtws_pkg::REG_SLOTS_45:     prdata = cfg_q.slots[2];
      wtws_pkg::REG_SLOTS_67:     prdata = cfg_q.slots[3];
      wtws_pkg::REG_START_DAY:    prdata = 64'(cfg_q.start_day);
      wtws_pkg::REG_START_YEAR:   prdata = 64'(cfg_q.start_year);
      wtws_pkg::REG_RUN_WEEKS:    prdata = 64'(cfg_q.run_weeks);
      wtws_pkg::REG_NEVER_EXPIRE: prdata = 64'(cfg_q.never_expire);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/wtws_slot_check.sv
`timescale 1ns / 1ps

// Checks one slot descriptor against the current weekday and time of day.
module wtws_slot_check (
  input  wtws_pkg::slot_t slot_i,
  input  logic [2:0]      wday_i,
  input  logic [4:0]      hour_i,
  input  logic [5:0]      min_i,
  output logic            hit_o
);

  logic [2:0]  wday_m;
  logic        day_ok;
  logic [10:0] now_t;
  logic [10:0] start_t;
  logic [6:0]  min_sum;
  logic [1:0]  carry;
  logic [6:0]  end_m;
  logic [6:0]  end_h;
  logic        past_end;

  // Sunday counts as day seven.
  assign wday_m = (wday_i == 3'd0) ? 3'd7 : wday_i;
  assign day_ok = (slot_i.day == {1'b0, wday_m}) || (slot_i.day == wtws_pkg::DAY_ANY);

  // Times as minutes since midnight.
  assign now_t   = 11'(hour_i) * 11'd60 + 11'(min_i);
  assign start_t = 11'(slot_i.start_hour) * 11'd60 + 11'(slot_i.start_min);

  // End of the window: the minute sum stays below three hours.
  assign min_sum = 7'(slot_i.start_min) + 7'(slot_i.dur_min);
  always_comb begin
    if (min_sum >= 7'(2 * wtws_pkg::MIN_PER_HOUR)) begin
      carry = 2'd2;
      end_m = min_sum - 7'(2 * wtws_pkg::MIN_PER_HOUR);
    end else if (min_sum >= wtws_pkg::MIN_PER_HOUR) begin
      carry = 2'd1;
      end_m = min_sum - wtws_pkg::MIN_PER_HOUR;
    end else begin
      carry = 2'd0;
      end_m = min_sum;
    end
  end
  assign end_h = 7'(slot_i.start_hour) + 7'(slot_i.dur_hour) + 7'(carry);

  assign past_end = (7'(hour_i) > end_h) || ((7'(hour_i) == end_h) && (7'(min_i) > end_m));

  assign hit_o = slot_i.enable && day_ok && (now_t >= start_t) && !past_end;

endmodule

FILE: src/weekly_time_window_scheduler_unit.sv
`timescale 1ns / 1ps

// Weekly time-window scheduler. Each tick on the input stream is checked against
// up to eight schedule slots, one slot per clock through a single compare unit,
// and yields zero, one or two start/end messages on the output stream. The block
// takes one tick at a time: after the accepting cycle a tick passes an expiry step
// that unwraps the expiry date by 365 days at a time (at most six times, none when
// expiry is off), then the slot search (both skipped when paused, the search also
// when the schedule has run out), then a decision step, then each message, held
// until the receiver takes it, and a return to idle; s_axis_tready is high only
// between ticks.
module weekly_time_window_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick stream. tdata from bit 0: now_wday[2:0], now_hour[7:3], now_min[13:8],
  // now_yday[22:14], now_year[30:23], paused[31], rec_dest[33:32],
  // card_absent[34], zero[39:35].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Message stream. tdata from bit 0: slot_index[2:0], zero[7:3].
  // tuser: msg_kind. tlast: last message of the tick.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPIRY = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  wtws_pkg::cfg_t  cfg;
  wtws_pkg::tick_t tick_in;
  wtws_pkg::tick_t tick_q, tick_d;
  wtws_pkg::slot_t cur_slot;
  logic [63:0]     slot_pair;
  logic            slot_hit;

  logic [2:0]  state_q, state_d;
  logic [2:0]  idx_q, idx_d;
  logic        found_q, found_d;
  logic [11:0] end_day_q, end_day_d;
  logic [8:0]  end_year_q, end_year_d;
  logic [1:0]  active_dest_q, active_dest_d;
  logic [3:0]  repeat_q, repeat_d;
  logic [1:0]  kind_q, kind_d;
  logic [5:0]  slot_out_q, slot_out_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        out_idx_q, out_idx_d;
  logic        expired;

  wtws_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Slot under test: pair register by the upper index bits, half by the lowest.
  assign slot_pair = cfg.slots[idx_q[2:1]];
  assign cur_slot  = idx_q[0] ? slot_pair[63:32] : slot_pair[31:0];

  wtws_slot_check u_check (
    .slot_i (cur_slot),
    .wday_i (tick_q.now_wday),
    .hour_i (tick_q.now_hour),
    .min_i  (tick_q.now_min),
    .hit_o  (slot_hit)
  );

  assign tick_in = wtws_pkg::tick_t'(s_axis_tdata);

  assign expired = (12'(tick_q.now_yday) > end_day_q) &&
                   ({1'b0, tick_q.now_year} >= end_year_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tuser  = kind_q[out_idx_q];
  assign m_axis_tdata  = {5'd0, out_idx_q ? slot_out_q[5:3] : slot_out_q[2:0]};
  assign m_axis_tlast  = ({1'b0, out_idx_q} == cnt_q - 2'd1);

  // Sequencer: expiry wrap, slot search, decision, message delivery.
  always_comb begin
    state_d       = state_q;
    tick_d        = tick_q;
    idx_d         = idx_q;
    found_d       = found_q;
    end_day_d     = end_day_q;
    end_year_d    = end_year_q;
    active_dest_d = active_dest_q;
    repeat_d      = repeat_q;
    kind_d        = kind_q;
    slot_out_d    = slot_out_q;
    cnt_d         = cnt_q;
    out_idx_d     = out_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          tick_d     = tick_in;
          idx_d      = '0;
          found_d    = 1'b0;
          end_day_d  = 12'(cfg.start_day) + (12'(cfg.run_weeks) << 3) - 12'(cfg.run_weeks);
          end_year_d = 9'(cfg.start_year);
          state_d    = tick_in.paused ? ST_DECIDE : ST_EXPIRY;
        end
      end
      ST_EXPIRY: begin
        if (cfg.never_expire) begin
          state_d = ST_SCAN;
        end else if (end_day_q > wtws_pkg::YEAR_DAYS) begin
          end_day_d  = end_day_q - wtws_pkg::YEAR_DAYS;
          end_year_d = end_year_q + 9'd1;
        end else begin
          state_d = expired ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (slot_hit) begin
          found_d = 1'b1;
          state_d = ST_DECIDE;
        end else if (idx_q == 3'(wtws_pkg::SLOTS - 1)) begin
          state_d = ST_DECIDE;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_DECIDE: begin
        cnt_d      = 2'd0;
        out_idx_d  = 1'b0;
        kind_d     = {wtws_pkg::MSG_START, wtws_pkg::MSG_START};
        slot_out_d = '0;
        if (found_q) begin
          if (tick_q.card_absent) begin
            if (repeat_q == 4'd0) begin
              cnt_d      = 2'd1;
              slot_out_d = {3'd0, idx_q};
              repeat_d   = wtws_pkg::REPEAT_RELOAD;
            end else begin
              repeat_d = repeat_q - 4'd1;
            end
          end else if (tick_q.rec_dest != 2'd0) begin
            if (active_dest_q == 2'd0) begin
              cnt_d      = 2'd1;
              slot_out_d = {3'd0, idx_q};
            end else if (active_dest_q != tick_q.rec_dest) begin
              cnt_d      = 2'd2;
              kind_d     = {wtws_pkg::MSG_START, wtws_pkg::MSG_END};
              slot_out_d = {idx_q, 3'd0};
            end
          end else if (active_dest_q != 2'd0) begin
            cnt_d  = 2'd1;
            kind_d = {wtws_pkg::MSG_START, wtws_pkg::MSG_END};
          end
          active_dest_d = tick_q.rec_dest;
        end else begin
          if (active_dest_q != 2'd0) begin
            cnt_d  = 2'd1;
            kind_d = {wtws_pkg::MSG_START, wtws_pkg::MSG_END};
          end
          active_dest_d = 2'd0;
          repeat_d      = 4'd0;
        end
        state_d = (cnt_d == 2'd0) ? ST_IDLE : ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          if (m_axis_tlast) begin
            state_d = ST_IDLE;
          end else begin
            out_idx_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_dest_q <= '0;
      repeat_q      <= '0;
      cnt_q         <= '0;
      out_idx_q     <= 1'b0;
      found_q       <= 1'b0;
      idx_q         <= '0;
    end else begin
      state_q       <= state_d;
      active_dest_q <= active_dest_d;
      repeat_q      <= repeat_d;
      cnt_q         <= cnt_d;
      out_idx_q     <= out_idx_d;
      found_q       <= found_d;
      idx_q         <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tick_q     <= tick_d;
    end_day_q  <= end_day_d;
    end_year_q <= end_year_d;
    kind_q     <= kind_d;
    slot_out_q <= slot_out_d;
  end

endmodule
